### rtl/sfe_pkg.sv
// sfe_pkg: shared types and constants for the shortest float encoder.
// Used by sfe_narrow and shortest_float_encoder_top. No dependencies.
package sfe_pkg;

  localparam logic [7:0] HEAD_HALF   = 8'hf9;
  localparam logic [7:0] HEAD_SINGLE = 8'hfa;
  localparam logic [7:0] HEAD_DOUBLE = 8'hfb;

  localparam logic [3:0] BYTES_HALF   = 4'd2;
  localparam logic [3:0] BYTES_SINGLE = 4'd4;
  localparam logic [3:0] BYTES_DOUBLE = 4'd8;

  localparam logic [15:0] HALF_NAN  = 16'h7e00;
  localparam logic [15:0] HALF_PINF = 16'h7c00;
  localparam logic [15:0] HALF_NINF = 16'hfc00;

  localparam logic [10:0] DBL_EXP_ONES = 11'h7ff;

  // exponent rebias: double->single (1023-127), single->half (127-15)
  localparam logic signed [11:0] SGL_REBIAS  = 12'sd896;
  localparam logic signed [11:0] HLF_REBIAS  = 12'sd112;
  localparam logic signed [11:0] SGL_EXP_MAX = 12'sd254;
  localparam logic signed [11:0] HLF_EXP_MAX = 12'sd30;
  // lowest exponent whose denormal shift stays within the fraction width
  localparam logic signed [11:0] SGL_SUB_MIN = -12'sd22;
  localparam logic signed [11:0] HLF_SUB_MIN = -12'sd9;

  typedef struct packed {
    logic [7:0]  head_byte;
    logic [3:0]  payload_bytes;
    logic [63:0] payload_bits;
  } result_t;

endpackage

### rtl/sfe_narrow.sv
// sfe_narrow: combinational choice of the shortest exact float encoding.
// Depends on sfe_pkg (result_t, head codes, rebias constants).
module sfe_narrow (
  input  logic [63:0]      double_bits,
  output sfe_pkg::result_t result
);

  logic                sign;
  logic [10:0]         exp64;
  logic [51:0]         frac64;
  logic                is_zero;
  logic                is_special;
  logic signed [11:0]  e32;
  logic signed [11:0]  n32_full;
  logic [4:0]          n32;
  logic [23:0]         s24;
  logic [23:0]         mask24;
  logic [23:0]         sub32;
  logic                sgl_norm;
  logic                sgl_sub;
  logic                sgl_ok;
  logic [7:0]          expf32;
  logic [22:0]         frac32;
  logic signed [11:0]  e16;
  logic signed [11:0]  n16_full;
  logic [3:0]          n16;
  logic [10:0]         s11;
  logic [10:0]         mask11;
  logic [10:0]         sub16;
  logic                hlf_norm;
  logic                hlf_sub;
  logic                hlf_ok;
  logic [4:0]          expf16;
  logic [9:0]          frac16;
  logic [15:0]         special16;

  assign sign   = double_bits[63];
  assign exp64  = double_bits[62:52];
  assign frac64 = double_bits[51:0];

  assign is_zero    = (double_bits[62:0] == 63'd0);
  assign is_special = (exp64 == sfe_pkg::DBL_EXP_ONES);

  // single precision
  assign e32      = $signed({1'b0, exp64}) - sfe_pkg::SGL_REBIAS;
  assign n32_full = 12'sd1 - e32;
  assign n32      = n32_full[4:0];
  assign s24      = {1'b1, frac64[51:29]};
  assign mask24   = (24'd1 << n32) - 24'd1;
  assign sub32    = s24 >> n32;
  assign sgl_norm = (e32 > 12'sd0) && (e32 <= sfe_pkg::SGL_EXP_MAX);
  assign sgl_sub  = (e32 <= 12'sd0) && (e32 >= sfe_pkg::SGL_SUB_MIN);
  assign sgl_ok   = (frac64[28:0] == 29'd0) &&
                    (sgl_norm || (sgl_sub && ((s24 & mask24) == 24'd0)));
  assign expf32   = sgl_norm ? e32[7:0] : 8'd0;
  assign frac32   = sgl_norm ? frac64[51:29] : sub32[22:0];

  // half precision, only from a normal single
  assign e16      = e32 - sfe_pkg::HLF_REBIAS;
  assign n16_full = 12'sd1 - e16;
  assign n16      = n16_full[3:0];
  assign s11      = {1'b1, frac64[51:42]};
  assign mask11   = (11'd1 << n16) - 11'd1;
  assign sub16    = s11 >> n16;
  assign hlf_norm = sgl_norm && (e16 > 12'sd0) && (e16 <= sfe_pkg::HLF_EXP_MAX);
  assign hlf_sub  = sgl_norm && (e16 <= 12'sd0) && (e16 >= sfe_pkg::HLF_SUB_MIN);
  assign hlf_ok   = sgl_ok && (frac64[41:29] == 13'd0) &&
                    (hlf_norm || (hlf_sub && ((s11 & mask11) == 11'd0)));
  assign expf16   = hlf_norm ? e16[4:0] : 5'd0;
  assign frac16   = hlf_norm ? frac64[51:42] : sub16[9:0];

  always_comb begin
    if (frac64 != 52'd0) begin
      special16 = sfe_pkg::HALF_NAN;
    end else if (sign) begin
      special16 = sfe_pkg::HALF_NINF;
    end else begin
      special16 = sfe_pkg::HALF_PINF;
    end
  end

  always_comb begin
    if (is_zero) begin
      result.head_byte     = sfe_pkg::HEAD_HALF;
      result.payload_bytes = sfe_pkg::BYTES_HALF;
      result.payload_bits  = {48'd0, sign, 15'd0};
    end else if (is_special) begin
      result.head_byte     = sfe_pkg::HEAD_HALF;
      result.payload_bytes = sfe_pkg::BYTES_HALF;
      result.payload_bits  = {48'd0, special16};
    end else if (hlf_ok) begin
      result.head_byte     = sfe_pkg::HEAD_HALF;
      result.payload_bytes = sfe_pkg::BYTES_HALF;
      result.payload_bits  = {48'd0, sign, expf16, frac16};
    end else if (sgl_ok) begin
      result.head_byte     = sfe_pkg::HEAD_SINGLE;
      result.payload_bytes = sfe_pkg::BYTES_SINGLE;
      result.payload_bits  = {32'd0, sign, expf32, frac32};
    end else begin
      result.head_byte     = sfe_pkg::HEAD_DOUBLE;
      result.payload_bytes = sfe_pkg::BYTES_DOUBLE;
      result.payload_bits  = double_bits;
    end
  end

endmodule

### rtl/shortest_float_encoder_top.sv
// shortest_float_encoder_top: input register, narrowing logic, result register.
// Depends on sfe_pkg and sfe_narrow.
//
// Usage:
//   Request channel: double_valid / double_stall with double_bits, the raw
//   binary64 pattern. A request is taken on a rising edge with double_valid
//   high and double_stall low.
//   Result channel: result_valid / result_stall with head_byte (0xf9, 0xfa,
//   0xfb), payload_bytes (2, 4, 8) and payload_bits (right aligned).
//   Every request yields exactly one result, in order.
//   Path: input register, then result register, then result_valid rises.
//   Throughput: one request per cycle while result_stall is low, set by the
//   single combinational pass of sfe_narrow between the two registers.
//   Stall: while result_stall holds, the result register keeps its value and
//   the input register still takes one more request; double_stall rises only
//   when both registers hold an item and the result is not taken.
//   Reset (rst, synchronous, active high) empties both registers; no other
//   state exists.
module shortest_float_encoder_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        double_valid,
  output logic        double_stall,
  input  logic [63:0] double_bits,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  head_byte,
  output logic [3:0]  payload_bytes,
  output logic [63:0] payload_bits
);

  logic             s1_valid;
  logic [63:0]      s1_bits;
  logic             adv_out;
  logic             adv_s1;
  sfe_pkg::result_t narrow_result;

  assign adv_out      = !result_valid || !result_stall;
  assign adv_s1       = !s1_valid || adv_out;
  assign double_stall = !adv_s1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv_s1) begin
      s1_valid <= double_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s1 && double_valid) begin
      s1_bits <= double_bits;
    end
  end

  sfe_narrow u_narrow (
    .double_bits (s1_bits),
    .result      (narrow_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv_out) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_out && s1_valid) begin
      head_byte     <= narrow_result.head_byte;
      payload_bytes <= narrow_result.payload_bytes;
      payload_bits  <= narrow_result.payload_bits;
    end
  end

  a_head_len: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (head_byte == sfe_pkg::HEAD_HALF   && payload_bytes == sfe_pkg::BYTES_HALF) ||
      (head_byte == sfe_pkg::HEAD_SINGLE && payload_bytes == sfe_pkg::BYTES_SINGLE) ||
      (head_byte == sfe_pkg::HEAD_DOUBLE && payload_bytes == sfe_pkg::BYTES_DOUBLE))
    else $error("head byte and payload length disagree");

  a_upper_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (head_byte == sfe_pkg::HEAD_DOUBLE) ||
      (head_byte == sfe_pkg::HEAD_SINGLE && payload_bits[63:32] == 32'd0) ||
      (head_byte == sfe_pkg::HEAD_HALF && payload_bits[63:16] == 48'd0))
    else $error("payload upper bits not zero");

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    double_stall |-> (s1_valid && result_valid && result_stall))
    else $error("request stalled with room in the pipeline");

  a_accept_held: assert property (@(posedge clk) disable iff (rst)
    (double_valid && !double_stall) |=> s1_valid)
    else $error("accepted request lost from input register");

  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_stall) |=> result_valid)
    else $error("stalled result dropped");

endmodule

### sim/tb_shortest_float_encoder_top.sv
// tb_shortest_float_encoder_top: self-checking bench for the shortest float encoder.
// Predicts head byte, payload length and payload bits for each accepted double.
// Depends on sfe_pkg and shortest_float_encoder_top.
module tb_shortest_float_encoder_top;

  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        double_valid = 1'b0;
  logic        double_stall;
  logic [63:0] double_bits = '0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  head_byte;
  logic [3:0]  payload_bytes;
  logic [63:0] payload_bits;

  sfe_pkg::result_t expected_encodings[$];
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      recv_stall_pct = 0;
  logic    receiver_hold = 1'b0;
  event    start_hold;

  shortest_float_encoder_top dut (
    .clk(clk),
    .rst(rst),
    .double_valid(double_valid),
    .double_stall(double_stall),
    .double_bits(double_bits),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .head_byte(head_byte),
    .payload_bytes(payload_bytes),
    .payload_bits(payload_bits)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Denormalize into a format with frac_width fraction bits; 0 if a bit would drop.
  function automatic bit fits_subnormal(inout int exp_b, inout logic [63:0] frac,
                                        input int frac_width);
    logic [63:0] full;
    int          shift;
    if (exp_b > 0) return 1'b1;
    full = frac + (64'd1 << frac_width);
    shift = 1 - exp_b;
    if (shift > frac_width) return 1'b0;
    if ((full & ((64'd1 << shift) - 64'd1)) != 64'd0) return 1'b0;
    frac = full >> shift;
    exp_b = 0;
    return 1'b1;
  endfunction

  function automatic sfe_pkg::result_t encode_shortest(input logic [63:0] v);
    sfe_pkg::result_t r;
    int               exp_b;
    logic [63:0]      frac;
    logic [31:0]      f32;
    r = '{sfe_pkg::HEAD_DOUBLE, sfe_pkg::BYTES_DOUBLE, v};
    if (v[62:0] == 63'd0) begin
      r = '{sfe_pkg::HEAD_HALF, sfe_pkg::BYTES_HALF, {48'd0, v[63], 15'd0}};
    end else if (v[62:52] == sfe_pkg::DBL_EXP_ONES) begin
      if (v == {1'b0, sfe_pkg::DBL_EXP_ONES, 52'd0})
        r = '{sfe_pkg::HEAD_HALF, sfe_pkg::BYTES_HALF, {48'd0, sfe_pkg::HALF_PINF}};
      else if (v == {1'b1, sfe_pkg::DBL_EXP_ONES, 52'd0})
        r = '{sfe_pkg::HEAD_HALF, sfe_pkg::BYTES_HALF, {48'd0, sfe_pkg::HALF_NINF}};
      else
        r = '{sfe_pkg::HEAD_HALF, sfe_pkg::BYTES_HALF, {48'd0, sfe_pkg::HALF_NAN}};
    end else begin
      exp_b = int'(v[62:52]) - int'(sfe_pkg::SGL_REBIAS);
      frac = {12'd0, v[51:0]};
      if (exp_b <= int'(sfe_pkg::SGL_EXP_MAX) && frac[28:0] == 29'd0) begin
        frac = frac >> 29;
        if (fits_subnormal(exp_b, frac, 23)) begin
          f32 = {v[63], exp_b[7:0], frac[22:0]};
          r = '{sfe_pkg::HEAD_SINGLE, sfe_pkg::BYTES_SINGLE, {32'd0, f32}};
          exp_b = exp_b - int'(sfe_pkg::HLF_REBIAS);
          if (exp_b <= int'(sfe_pkg::HLF_EXP_MAX) && frac[12:0] == 13'd0) begin
            frac = frac >> 13;
            if (fits_subnormal(exp_b, frac, 10))
              r = '{sfe_pkg::HEAD_HALF, sfe_pkg::BYTES_HALF,
                    {48'd0, v[63], exp_b[4:0], frac[9:0]}};
          end
        end
      end
    end
    return r;
  endfunction

  // Often values near the half and single ranges with few significant fraction bits.
  function automatic logic [63:0] random_double();
    logic [63:0] v;
    int          keep_bits;
    v = {$urandom, $urandom};
    keep_bits = 52;
    case ($urandom_range(0, 9))
      0, 1: ;
      2, 3: begin
        v[62:52] = 11'($urandom_range(985, 1042));
        keep_bits = $urandom_range(0, 12);
      end
      4, 5: begin
        v[62:52] = 11'($urandom_range(866, 1154));
        keep_bits = $urandom_range(0, 26);
      end
      6: begin
        v[62:52] = sfe_pkg::DBL_EXP_ONES;
        keep_bits = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 52);
      end
      7: begin
        v[62:52] = 11'd0;
        keep_bits = $urandom_range(0, 52);
      end
      8: keep_bits = $urandom_range(0, 30);
      default: v[62:0] = 63'd0;
    endcase
    v[51:0] = v[51:0] & ~({52{1'b1}} >> keep_bits);
    return v;
  endfunction

  task automatic send_double(input logic [63:0] bits);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      double_valid <= 1'b0;
      @(posedge clk);
    end
    double_valid <= 1'b1;
    double_bits <= bits;
    do @(posedge clk); while (double_stall);
    expected_encodings.push_back(encode_shortest(bits));
  endtask

  task automatic run_random(input int count, input int idle_pct, input int stall_pct);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) send_double(random_double());
  endtask

  task automatic test_corner_values();
    logic [63:0] corner_values [25] = '{
      64'h0000000000000000, 64'h8000000000000000, 64'h7FF0000000000000,
      64'hFFF0000000000000, 64'h7FF8000000000000, 64'hFFF0000000000001,
      64'h7FFFFFFFFFFFFFFF, 64'h0000000000000001, 64'h800FFFFFFFFFFFFF,
      64'h3FF0000000000000, 64'hC0EFFC0000000000, 64'h40EFFE0000000000,
      64'h3E70000000000000, 64'h3E60000000000000, 64'h3E78000000000000,
      64'h36A0000000000000, 64'h3690000000000000, 64'h47EFFFFFE0000000,
      64'h47F0000000000000, 64'h3FF0000000000001, 64'h3FF0000020000000,
      64'h3FF0040000000000, 64'h3FF0020000000000, 64'h7FEFFFFFFFFFFFFF,
      64'h3F10000000000000
    };
    send_idle_pct = 0;
    recv_stall_pct = 0;
    foreach (corner_values[i]) send_double(corner_values[i]);
  endtask

  task automatic test_streaming();
    run_random(350, 0, 0);
  endtask

  task automatic test_sender_gaps();
    run_random(350, 85, 0);
  endtask

  task automatic test_receiver_stalls();
    run_random(350, 0, 85);
  endtask

  task automatic test_mixed_idling();
    run_random(350, 12, 12);
  endtask

  // Receiver holds off while requests keep coming, so the block fills and stalls.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    -> start_hold;
    repeat (40) send_double(random_double());
    run_random(310, 12, 12);
  endtask

  initial begin
    forever begin
      @(start_hold);
      receiver_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      receiver_hold <= 1'b0;
    end
  end

  always @(posedge clk)
    result_stall <= receiver_hold || ($urandom_range(0, 99) < recv_stall_pct);

  always @(posedge clk) begin
    sfe_pkg::result_t exp_r;
    if (!rst && result_valid && !result_stall) begin
      if (expected_encodings.size() == 0) begin
        $error("unexpected result: head_byte %h payload_bits %h", head_byte, payload_bits);
        error_count++;
      end else begin
        exp_r = expected_encodings.pop_front();
        if (head_byte !== exp_r.head_byte) begin
          $error("head_byte: expected %h, got %h", exp_r.head_byte, head_byte);
          error_count++;
        end
        if (payload_bytes !== exp_r.payload_bytes) begin
          $error("payload_bytes: expected %0d, got %0d", exp_r.payload_bytes, payload_bytes);
          error_count++;
        end
        if (payload_bits !== exp_r.payload_bits) begin
          $error("payload_bits: expected %h, got %h", exp_r.payload_bits, payload_bits);
          error_count++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_corner_values();
    test_streaming();
    test_sender_gaps();
    test_receiver_stalls();
    test_mixed_idling();
    test_output_backpressure();
    double_valid <= 1'b0;
    while (expected_encodings.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule
